// ----- rtl/sst_pkg.sv -----
`timescale 1ns / 1ps

package sst_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int HANDLE_W      = 64;
   localparam int STATUS_W      = 3;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK        = 3'd0;
   localparam status_type STATUS_INVALID   = 3'd1;
   localparam status_type STATUS_PRESENT   = 3'd2;
   localparam status_type STATUS_FULL      = 3'd3;
   localparam status_type STATUS_NOT_FOUND = 3'd4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

endpackage

// ----- rtl/sst_slot_mem.sv -----
`timescale 1ns / 1ps

module sst_slot_mem #(
   parameter int SLOTS = sst_pkg::SLOTS_DEFAULT,
   parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [sst_pkg::HANDLE_W-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [sst_pkg::HANDLE_W-1:0] wr_data
);

   // An entry that was never written since reset reads as an empty slot.
   logic [sst_pkg::HANDLE_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]             written_ff;
   logic [sst_pkg::HANDLE_W-1:0] rd_data_ff;
   logic                         rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/subscriber_set_table.sv -----
`timescale 1ns / 1ps
// Each item reads every slot once through the single read port of the slot memory,
// then writes back at most one slot; no new item is taken until its result is issued.
// Reset clears all control state and marks every slot empty at once; the
// block is ready to take an item as soon as reset is released.

module subscriber_set_table #(
   parameter int SLOTS = sst_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [sst_pkg::HANDLE_W-1:0]  req_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sst_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic                         op_ff, op_in;
   logic [sst_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic [CNT_W-1:0]             issue_cnt_ff, issue_cnt_in;
   logic                         ret_valid_ff, ret_valid_in;
   logic [IDX_W-1:0]             ret_idx_ff, ret_idx_in;
   logic                         match_found_ff, match_found_in;
   logic [IDX_W-1:0]             match_idx_ff, match_idx_in;
   logic                         empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]             empty_idx_ff, empty_idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   sst_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic [sst_pkg::HANDLE_W-1:0] rd_data;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [sst_pkg::HANDLE_W-1:0] wr_data;
   logic                         out_free;

   sst_slot_mem #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign rd_en   = (state_ff == ST_SCAN) && (issue_cnt_ff < CNT_W'(SLOTS));
   assign rd_addr = issue_cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      handle_in      = handle_ff;
      issue_cnt_in   = issue_cnt_ff;
      ret_valid_in   = rd_en;
      ret_idx_in     = rd_addr;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      wr_addr        = empty_idx_ff;
      wr_data        = handle_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in          = req_op;
               handle_in      = req_handle;
               issue_cnt_in   = '0;
               match_found_in = 1'b0;
               empty_found_in = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
            if (ret_valid_ff) begin
               if (!match_found_ff && (rd_data == handle_ff)) begin
                  match_found_in = 1'b1;
                  match_idx_in   = ret_idx_ff;
               end
               if (!empty_found_ff && (rd_data == '0)) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = ret_idx_ff;
               end
               if (ret_idx_ff == IDX_W'(SLOTS - 1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (handle_ff == '0) begin
                  rsp_status_in = sst_pkg::STATUS_INVALID;
               end else if (op_ff == sst_pkg::OP_INSERT) begin
                  if (match_found_ff) begin
                     rsp_status_in = sst_pkg::STATUS_PRESENT;
                  end else if (!empty_found_ff) begin
                     rsp_status_in = sst_pkg::STATUS_FULL;
                  end else begin
                     rsp_status_in = sst_pkg::STATUS_OK;
                     wr_en         = 1'b1;
                     wr_addr       = empty_idx_ff;
                     wr_data       = handle_ff;
                  end
               end else begin
                  if (!match_found_ff) begin
                     rsp_status_in = sst_pkg::STATUS_NOT_FOUND;
                  end else begin
                     rsp_status_in = sst_pkg::STATUS_OK;
                     wr_en         = 1'b1;
                     wr_addr       = match_idx_ff;
                     wr_data       = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         issue_cnt_ff   <= '0;
         ret_valid_ff   <= 1'b0;
         match_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_cnt_ff   <= issue_cnt_in;
         ret_valid_ff   <= ret_valid_in;
         match_found_ff <= match_found_in;
         empty_found_ff <= empty_found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      ret_idx_ff    <= ret_idx_in;
      match_idx_ff  <= match_idx_in;
      empty_idx_ff  <= empty_idx_in;
      rsp_status_ff <= rsp_status_in;
   end

   // A new result appears only at the end of a finished scan.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

   // The table is written back only once the whole scan is complete.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_FINISH) && (issue_cnt_ff == CNT_W'(SLOTS)))
      else $error("slot write before the scan completed");

   // Read data only returns while a scan is running.
   assert property (@(posedge clock) disable iff (reset)
      ret_valid_ff |-> (state_ff == ST_SCAN))
      else $error("read data returned outside a scan");

   // The finish step never overwrites a result that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_status_ff))
      else $error("pending result changed");

endmodule

// ----- bench/sst_status_checker.sv -----
`timescale 1ns / 1ps

module sst_status_checker #(
   parameter int SLOTS = sst_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_op,
   input  logic [sst_pkg::HANDLE_W-1:0]  req_handle,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [sst_pkg::STATUS_W-1:0]  rsp_status,
   output int                            error_count,
   output int                            outstanding
);

   logic [sst_pkg::HANDLE_W-1:0] shadow_slots [SLOTS];
   sst_pkg::status_type          expected_status [$];

   function automatic sst_pkg::status_type predict_status(
      input logic                         op,
      input logic [sst_pkg::HANDLE_W-1:0] handle);
      int hit;
      int empty_slot;
      hit        = -1;
      empty_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && shadow_slots[i] == handle) begin
            hit = i;
         end
         if (empty_slot < 0 && shadow_slots[i] == '0) begin
            empty_slot = i;
         end
      end
      if (handle == '0) begin
         return sst_pkg::STATUS_INVALID;
      end
      if (op == sst_pkg::OP_INSERT) begin
         if (hit >= 0) begin
            return sst_pkg::STATUS_PRESENT;
         end
         if (empty_slot < 0) begin
            return sst_pkg::STATUS_FULL;
         end
         shadow_slots[empty_slot] = handle;
         return sst_pkg::STATUS_OK;
      end
      if (hit < 0) begin
         return sst_pkg::STATUS_NOT_FOUND;
      end
      shadow_slots[hit] = '0;
      return sst_pkg::STATUS_OK;
   endfunction

   always @(posedge clock) begin
      sst_pkg::status_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            shadow_slots[i] = '0;
         end
         expected_status.delete();
         error_count <= 0;
      end else begin
         // A result always belongs to an older request, so it is checked
         // before the request taken at the same edge is predicted.
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $error("status: expected none, actual %0d", rsp_status);
               error_count <= error_count + 1;
            end else begin
               want = expected_status.pop_front();
               if (rsp_status !== want) begin
                  $error("status: expected %0d, actual %0d", want, rsp_status);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_status.push_back(predict_status(req_op, req_handle));
         end
      end
      outstanding <= expected_status.size();
   end

endmodule

// ----- bench/tb_subscriber_set_table.sv -----
`timescale 1ns / 1ps

module tb_subscriber_set_table;

   localparam int    SLOTS        = sst_pkg::SLOTS_DEFAULT;
   localparam int    PHASE_ITEMS  = 150;
   localparam int    POOL_SIZE    = 24;
   localparam int    LONG_HOLD    = 300;
   localparam longint CYCLE_LIMIT = 500000;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_valid  = 1'b0;
   logic                          req_op     = sst_pkg::OP_INSERT;
   logic [sst_pkg::HANDLE_W-1:0]  req_handle = '0;
   logic                          rsp_ready  = 1'b0;
   logic                          req_ready;
   logic                          rsp_valid;
   logic [sst_pkg::STATUS_W-1:0]  rsp_status;

   int     error_count;
   int     outstanding;
   int     send_idle_pct  = 0;
   int     recv_stall_pct = 0;
   int     insert_pct     = 50;
   int     hold_len       = 0;
   int     hold_left      = 0;
   longint cycle_count    = 0;

   logic [sst_pkg::HANDLE_W-1:0] handle_pool [POOL_SIZE];

   subscriber_set_table #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_handle (req_handle),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status)
   );

   sst_status_checker #(.SLOTS(SLOTS)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_handle  (req_handle),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_request(input logic op,
                               input logic [sst_pkg::HANDLE_W-1:0] handle);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_handle <= handle;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic random_phase(input int count, input bit with_hold);
      int                           pick;
      logic                         op;
      logic [sst_pkg::HANDLE_W-1:0] handle;
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 3) begin
            hold_len = LONG_HOLD;
         end
         pick = $urandom_range(99);
         if (pick < 5) begin
            op     = 1'($urandom_range(1));
            handle = '0;
         end else if (pick < 15) begin
            // Unknown handles are only removed so that the table never
            // fills with entries the sequence cannot reach again.
            op     = sst_pkg::OP_REMOVE;
            handle = {$urandom, $urandom};
         end else begin
            op     = ($urandom_range(99) < insert_pct) ? sst_pkg::OP_INSERT
                                                       : sst_pkg::OP_REMOVE;
            handle = handle_pool[$urandom_range(POOL_SIZE - 1)];
         end
         send_request(op, handle);
      end
   endtask

   initial begin
      handle_pool[0] = '1;
      handle_pool[1] = 64'd1;
      handle_pool[2] = 64'h8000_0000_0000_0000;
      for (int i = 3; i < POOL_SIZE; i++) begin
         handle_pool[i] = {$urandom, $urandom};
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(sst_pkg::OP_REMOVE, '0);
      send_request(sst_pkg::OP_INSERT, '0);
      send_request(sst_pkg::OP_REMOVE, handle_pool[0]);
      send_request(sst_pkg::OP_INSERT, handle_pool[0]);
      send_request(sst_pkg::OP_INSERT, handle_pool[0]);
      send_request(sst_pkg::OP_INSERT, handle_pool[1]);
      send_request(sst_pkg::OP_INSERT, handle_pool[2]);
      for (int i = 3; i < SLOTS; i++) begin
         send_request(sst_pkg::OP_INSERT, handle_pool[i]);
      end
      send_request(sst_pkg::OP_INSERT, handle_pool[SLOTS]);
      send_request(sst_pkg::OP_INSERT, handle_pool[1]);
      send_request(sst_pkg::OP_INSERT, '0);
      send_request(sst_pkg::OP_REMOVE, handle_pool[1]);
      send_request(sst_pkg::OP_INSERT, handle_pool[SLOTS]);
      send_request(sst_pkg::OP_REMOVE, handle_pool[0]);
      send_request(sst_pkg::OP_REMOVE, handle_pool[0]);
      wait_for_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 86;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 86;
            end
            default: begin
               send_idle_pct  = 32;
               recv_stall_pct = 32;
            end
         endcase
         insert_pct = $urandom_range(30, 70);
         random_phase(PHASE_ITEMS, phase == 0);
         wait_for_results();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (SLOTS + 3) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
